/* rtl/core/wlc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_pkg
// Shared types and constants of the weighted least-connection picker.
// ----------------------------------------------------------------------------
package wlc_pkg;

    localparam int NUM_SLOTS_DEF  = 8;
    localparam int COUNT_BITS_DEF = 16;

    localparam int WEIGHT_W   = 16;
    localparam int SLOT_W     = 3;
    localparam int CCOUNT_W   = 16;
    localparam int TAG_W      = 8;
    localparam int APB_DATA_W = 32;

    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 32;
    localparam int M_TUSER_W  = 1;

    localparam int SLOT_LSB   = 0;
    localparam int CCOUNT_LSB = SLOT_LSB + SLOT_W;
    localparam int TAG_LSB    = CCOUNT_LSB + CCOUNT_W;
    localparam int PAD_W      = M_TDATA_W - TAG_LSB - TAG_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MUL,
        ST_CMP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic mul;
        logic cmp;
        logic finish;
    } wlc_cmd_t;

    typedef struct packed {
        logic last;
        logic out_free;
    } wlc_status_t;

endpackage

/* rtl/core/wlc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wlc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/wlc_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_regs
// Slot weight registers behind the APB port, with a scan read port.
// ----------------------------------------------------------------------------
module wlc_regs #(
    parameter int NUM_SLOTS = wlc_pkg::NUM_SLOTS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [$clog2(NUM_SLOTS)+1:0]        paddr,
    input  logic [wlc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [wlc_pkg::APB_DATA_W-1:0]      prdata,
    input  logic [$clog2(NUM_SLOTS)-1:0]        scan_addr,
    output logic [wlc_pkg::WEIGHT_W-1:0]        scan_weight
);
    import wlc_pkg::*;

    localparam int IDX_W = $clog2(NUM_SLOTS);

    logic [IDX_W-1:0]    reg_idx;
    logic                in_range;
    logic                wr_en;
    logic [IDX_W-1:0]    rb_addr;
    logic [WEIGHT_W-1:0] rb_q;
    logic [WEIGHT_W-1:0] scan_q;

    logic [NUM_SLOTS-1:0] wvalid_reg;
    logic [NUM_SLOTS-1:0] wvalid_next;
    logic                 rb_ok_reg;
    logic                 scan_ok_reg;

    assign reg_idx  = paddr[IDX_W+1:2];
    assign in_range = {1'b0, reg_idx} < (IDX_W+1)'(NUM_SLOTS);
    assign wr_en    = psel && penable && pwrite && in_range;
    assign rb_addr  = in_range ? reg_idx : '0;

    // weight copy for the scan
    wlc_ram #(.WIDTH(WEIGHT_W), .DEPTH(NUM_SLOTS)) u_scan_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (reg_idx),
        .wdata (pwdata[WEIGHT_W-1:0]),
        .raddr (scan_addr),
        .rdata (scan_q)
    );

    // weight copy for register read-back
    wlc_ram #(.WIDTH(WEIGHT_W), .DEPTH(NUM_SLOTS)) u_rb_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (reg_idx),
        .wdata (pwdata[WEIGHT_W-1:0]),
        .raddr (rb_addr),
        .rdata (rb_q)
    );

    always_comb begin
        wvalid_next = wvalid_reg;
        if (wr_en) begin
            wvalid_next[reg_idx] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wvalid_reg  <= '0;
            rb_ok_reg   <= 1'b0;
            scan_ok_reg <= 1'b0;
        end else begin
            wvalid_reg  <= wvalid_next;
            rb_ok_reg   <= in_range && wvalid_reg[rb_addr];
            scan_ok_reg <= wvalid_reg[scan_addr];
        end
    end

    assign prdata      = rb_ok_reg ? {(APB_DATA_W-WEIGHT_W)'(0), rb_q} : '0;
    assign scan_weight = scan_ok_reg ? scan_q : '0;

endmodule

/* rtl/core/wlc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_ctrl
// Sequencer: accept a request, scan the slots, write back and emit the result.
// ----------------------------------------------------------------------------
module wlc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  wlc_pkg::wlc_status_t status,
    output wlc_pkg::wlc_cmd_t    cmd
);
    import wlc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: begin
                state_next = ST_MUL;
            end
            ST_MUL: begin
                state_next = ST_CMP;
            end
            ST_CMP: begin
                state_next = status.last ? ST_DONE : ST_MUL;
            end
            ST_DONE: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.start = s_tvalid;
            end
            ST_FETCH: begin
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
            end
            ST_CMP: begin
                cmd.cmp = 1'b1;
            end
            ST_DONE: begin
                cmd.finish = status.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/wlc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_dp
// Datapath: connection counts, cross-multiply compare, best-slot tracking
// and the result register.
// ----------------------------------------------------------------------------
module wlc_dp #(
    parameter int NUM_SLOTS  = wlc_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = wlc_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  wlc_pkg::wlc_cmd_t                cmd,
    output wlc_pkg::wlc_status_t             status,
    input  logic [wlc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic [$clog2(NUM_SLOTS)-1:0]     scan_addr,
    input  logic [wlc_pkg::WEIGHT_W-1:0]     scan_weight,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [wlc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [wlc_pkg::M_TUSER_W-1:0]    m_tuser
);
    import wlc_pkg::*;

    localparam int IDX_W  = $clog2(NUM_SLOTS);
    localparam int PROD_W = COUNT_BITS + WEIGHT_W;

    logic [IDX_W-1:0]      scan_idx_reg;
    logic [IDX_W-1:0]      rd_idx_reg;
    logic                  cvalid_q_reg;
    logic [NUM_SLOTS-1:0]  cvalid_reg;
    logic [NUM_SLOTS-1:0]  cvalid_next;
    logic [COUNT_BITS-1:0] count_q;
    logic [COUNT_BITS-1:0] rd_count;

    logic [IDX_W-1:0]      cur_idx_reg;
    logic [COUNT_BITS-1:0] cur_c_reg;
    logic [WEIGHT_W-1:0]   cur_w_reg;
    logic [PROD_W-1:0]     lhs_reg;
    logic [PROD_W-1:0]     rhs_reg;

    logic                  have_best_reg;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [COUNT_BITS-1:0] best_c_reg;
    logic [WEIGHT_W-1:0]   best_w_reg;
    logic [TAG_W-1:0]      tag_reg;

    logic [COUNT_BITS-1:0] new_count;
    logic                  wb_en;
    logic                  take;
    logic                  at_last;

    logic [IDX_W+SLOT_W-1:0]        slot_ext;
    logic [COUNT_BITS+CCOUNT_W-1:0] count_ext;

    logic                  m_tvalid_reg;
    logic [SLOT_W-1:0]     out_slot_reg;
    logic [CCOUNT_W-1:0]   out_count_reg;
    logic [TAG_W-1:0]      out_tag_reg;
    logic                  out_found_reg;

    assign scan_addr = scan_idx_reg;
    assign at_last   = scan_idx_reg == IDX_W'(NUM_SLOTS - 1);
    assign wb_en     = cmd.finish && have_best_reg;

    assign new_count = (best_c_reg == {COUNT_BITS{1'b1}}) ? best_c_reg
                                                          : best_c_reg + COUNT_BITS'(1);

    wlc_ram #(.WIDTH(COUNT_BITS), .DEPTH(NUM_SLOTS)) u_count_ram (
        .aclk  (aclk),
        .we    (wb_en),
        .waddr (best_idx_reg),
        .wdata (new_count),
        .raddr (scan_idx_reg),
        .rdata (count_q)
    );

    // never-written counts read as zero
    assign rd_count = cvalid_q_reg ? count_q : '0;

    always_comb begin
        cvalid_next = cvalid_reg;
        if (wb_en) begin
            cvalid_next[best_idx_reg] = 1'b1;
        end
    end

    assign take = (cur_w_reg != '0) && (!have_best_reg || (lhs_reg > rhs_reg));

    assign status.last     = cur_idx_reg == IDX_W'(NUM_SLOTS - 1);
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign slot_ext  = {{SLOT_W{1'b0}}, best_idx_reg};
    assign count_ext = {{CCOUNT_W{1'b0}}, new_count};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg  <= '0;
            cvalid_reg    <= '0;
            cvalid_q_reg  <= 1'b0;
            have_best_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            cvalid_reg   <= cvalid_next;
            cvalid_q_reg <= cvalid_reg[scan_idx_reg];

            if (cmd.start) begin
                scan_idx_reg  <= '0;
                have_best_reg <= 1'b0;
            end else if (cmd.mul && !at_last) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end

            if (cmd.cmp && take) begin
                have_best_reg <= 1'b1;
            end

            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg <= scan_idx_reg;

        if (cmd.start) begin
            tag_reg <= s_tdata[TAG_W-1:0];
        end

        if (cmd.mul) begin
            cur_idx_reg <= rd_idx_reg;
            cur_c_reg   <= rd_count;
            cur_w_reg   <= scan_weight;
            lhs_reg     <= best_c_reg * scan_weight;
            rhs_reg     <= rd_count * best_w_reg;
        end

        if (cmd.cmp && take) begin
            best_idx_reg <= cur_idx_reg;
            best_c_reg   <= cur_c_reg;
            best_w_reg   <= cur_w_reg;
        end

        if (cmd.finish) begin
            out_tag_reg   <= tag_reg;
            out_found_reg <= have_best_reg;
            out_slot_reg  <= have_best_reg ? slot_ext[SLOT_W-1:0] : '0;
            out_count_reg <= have_best_reg ? count_ext[CCOUNT_W-1:0] : '0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_tag_reg, out_count_reg, out_slot_reg};
    assign m_tuser  = out_found_reg;

endmodule

/* rtl/core/weighted_least_connection_picker.sv */
`timescale 1ns / 1ps
// a new request is taken only once the last scan has moved its result into the
//   output register; the scan runs one slot at a time through one multiply and
//   one compare stage
// requests are taken while an earlier result still waits in the output register
// reset: synchronous, active low; weights and counts read as zero through
//   per-entry valid bits, no clearing pass
// ----------------------------------------------------------------------------
// weighted_least_connection_picker
// Picks the server slot with the least count/weight and bumps its count.
// ----------------------------------------------------------------------------
module weighted_least_connection_picker #(
    parameter int NUM_SLOTS  = wlc_pkg::NUM_SLOTS_DEF,
    parameter int COUNT_BITS = wlc_pkg::COUNT_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // request_tag
    input  logic [wlc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // chosen_slot, chosen_count, result_tag
    output logic [wlc_pkg::M_TDATA_W-1:0]    m_tdata,
    // found
    output logic [wlc_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [$clog2(NUM_SLOTS)+1:0]     paddr,
    input  logic [wlc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [wlc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import wlc_pkg::*;

    wlc_cmd_t                     cmd;
    wlc_status_t                  status;
    logic [$clog2(NUM_SLOTS)-1:0] scan_addr;
    logic [WEIGHT_W-1:0]          scan_weight;

    assign pready = 1'b1;

    wlc_regs #(.NUM_SLOTS(NUM_SLOTS)) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .scan_addr   (scan_addr),
        .scan_weight (scan_weight)
    );

    wlc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    wlc_dp #(.NUM_SLOTS(NUM_SLOTS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tdata     (s_tdata),
        .scan_addr   (scan_addr),
        .scan_weight (scan_weight),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

/* rtl/core/wlc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wlc_checker
// Port-level checks of the picker, bound to the top level.
// ----------------------------------------------------------------------------
module wlc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [wlc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [wlc_pkg::M_TUSER_W-1:0] m_tuser
);
    import wlc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one request in flight at a time
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while another is in flight");

    // no slot found reports zero slot and count
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[TAG_LSB-1:0] == '0)
        else $error("empty pick carries slot or count");

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind weighted_least_connection_picker wlc_checker u_wlc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
